[rtl/core/crs_pkg.sv]
// crs_pkg: shared types for the comparison rank sorter
// holds the controller state enum and the controller/datapath command and status structs
// no dependencies
package crs_pkg;

   localparam int unsigned DataWidth = 32;

   // controller states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PIVOT,
      ST_SCAN,
      ST_DRAIN,
      ST_PLACE,
      ST_EMIT_RD,
      ST_EMIT_LOAD,
      ST_EMIT_OUT
   } crs_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic store;      // write accepted item into value store
      logic pivot_rd;   // read pivot value at rank index
      logic scan_clr;   // restart scan index and rank count
      logic scan_rd;    // read next scan value
      logic place;      // write pivot into sorted store at its rank
      logic rsp_load;   // load result register
      logic emit_next;  // advance emit index
      logic fill_clr;   // start a new set
   } crs_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic close_hit;  // current input item closes the set
      logic scan_end;   // scan index on last stored value
      logic pivot_end;  // pivot index on last stored value
      logic emit_end;   // emit index on last result
   } crs_sts_type;

endpackage

[rtl/core/crs_req_if.sv]
// crs_req_if: input channel of the comparison rank sorter
// valid/ready handshake carrying one value and its last mark
// no dependencies
interface crs_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] item_value;
   logic               last_in;

   modport source (output valid, output item_value, output last_in, input ready);
   modport sink (input valid, input item_value, input last_in, output ready);
endinterface

[rtl/core/crs_rsp_if.sv]
// crs_rsp_if: result channel of the comparison rank sorter
// valid/ready handshake carrying one sorted value and its last mark
// no dependencies
interface crs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sorted_value;
   logic               last_out;

   modport source (output valid, output sorted_value, output last_out, input ready);
   modport sink (input valid, input sorted_value, input last_out, output ready);
endinterface

[rtl/core/crs_ram.sv]
// crs_ram: generic one-write one-read memory with registered read data
// used for the value store and the sorted store
// no dependencies
module crs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/crs_ctrl.sv]
// crs_ctrl: sequencer for load, rank and emit phases
// depends on crs_pkg for the state enum and the command/status structs
// drives handshake ready/valid and datapath commands
module crs_ctrl
   import crs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  crs_sts_type sts,
   output crs_cmd_type cmd
);

   crs_state_type state_ff;
   crs_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && sts.close_hit) begin
               state_in = ST_PIVOT;
            end
         end
         ST_PIVOT: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            state_in = sts.pivot_end ? ST_EMIT_RD : ST_PIVOT;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (rsp_ready) begin
               state_in = sts.emit_end ? ST_LOAD : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.store = req_valid;
         end
         ST_PIVOT: begin
            cmd.pivot_rd = 1'b1;
            cmd.scan_clr = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
         end
         ST_EMIT_RD: begin
            // sorted store address is presented, data arrives next cycle
            cmd = '0;
         end
         ST_EMIT_LOAD: begin
            cmd.rsp_load = 1'b1;
         end
         ST_EMIT_OUT: begin
            rsp_valid      = 1'b1;
            cmd.emit_next  = rsp_ready;
            cmd.fill_clr   = rsp_ready && sts.emit_end;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/core/crs_dp.sv]
// crs_dp: value store, rank counter, sorted store and result register
// depends on crs_pkg for command/status structs and on crs_ram
// ranks each stored value by a sequential scan over the value store
module crs_dp
   import crs_pkg::*;
#(
   parameter int unsigned MAX_ITEMS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  crs_cmd_type          cmd,
   output crs_sts_type          sts,
   input  logic [DataWidth-1:0] req_item_value,
   input  logic                 req_last_in,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   output logic [DataWidth-1:0] rsp_sorted_value,
   output logic                 rsp_last_out
);

   localparam int unsigned IW = $clog2(MAX_ITEMS);
   localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

   logic [CW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [IW-1:0]        i_ff, i_in;
   logic [IW-1:0]        j_ff, j_in;
   logic [IW-1:0]        p_ff, p_in;
   logic [IW-1:0]        rank_ff, rank_in;
   logic [IW-1:0]        scan_idx_ff, scan_idx_in;
   logic                 scan_vld_ff, scan_vld_in;
   logic                 pivot_vld_ff, pivot_vld_in;
   logic                 asc_ff, asc_in;
   logic [DataWidth-1:0] pivot_ff, pivot_in;
   logic [DataWidth-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [IW-1:0]        n_last;
   logic [IW-1:0]        vs_rd_addr;
   logic [DataWidth-1:0] vs_rd_data;
   logic [IW-1:0]        ss_rd_addr;
   logic [DataWidth-1:0] ss_rd_data;
   logic                 scan_hit;

   assign n_last = IW'(n_ff - CW'(1));

   // value store, written in arrival order
   assign vs_rd_addr = cmd.pivot_rd ? i_ff : j_ff;

   crs_ram #(
      .WIDTH(DataWidth),
      .DEPTH(MAX_ITEMS)
   ) u_value_store (
      .clock  (clock),
      .wr_en  (cmd.store),
      .wr_addr(fill_ff[IW-1:0]),
      .wr_data(req_item_value),
      .rd_addr(vs_rd_addr),
      .rd_data(vs_rd_data)
   );

   // sorted store, written at each value's rank
   assign ss_rd_addr = asc_ff ? p_ff : IW'(n_last - p_ff);

   crs_ram #(
      .WIDTH(DataWidth),
      .DEPTH(MAX_ITEMS)
   ) u_sorted_store (
      .clock  (clock),
      .wr_en  (cmd.place),
      .wr_addr(rank_ff),
      .wr_data(pivot_ff),
      .rd_addr(ss_rd_addr),
      .rd_data(ss_rd_data)
   );

   // scanned value ranks below pivot: smaller, or equal and earlier
   assign scan_hit = scan_vld_ff &&
                     (($signed(vs_rd_data) < $signed(pivot_ff)) ||
                      (vs_rd_data == pivot_ff && scan_idx_ff < i_ff));

   // next values
   always_comb begin
      fill_in      = fill_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      p_in         = p_ff;
      rank_in      = rank_ff;
      scan_idx_in  = j_ff;
      scan_vld_in  = cmd.scan_rd;
      pivot_vld_in = cmd.pivot_rd;
      asc_in       = csr_wr_en ? csr_wr_data : asc_ff;
      pivot_in     = pivot_vld_ff ? vs_rd_data : pivot_ff;
      rsp_value_in = cmd.rsp_load ? ss_rd_data : rsp_value_ff;
      rsp_last_in  = cmd.rsp_load ? (p_ff == n_last) : rsp_last_ff;

      if (cmd.store) begin
         fill_in = fill_ff + CW'(1);
         n_in    = fill_ff + CW'(1);
         i_in    = '0;
         p_in    = '0;
      end
      if (cmd.fill_clr) begin
         fill_in = '0;
      end
      if (cmd.scan_clr) begin
         j_in    = '0;
         rank_in = '0;
      end else if (scan_hit) begin
         rank_in = rank_ff + IW'(1);
      end
      if (cmd.scan_rd) begin
         j_in = j_ff + IW'(1);
      end
      if (cmd.place) begin
         i_in = i_ff + IW'(1);
      end
      if (cmd.emit_next) begin
         p_in = p_ff + IW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         p_ff         <= '0;
         rank_ff      <= '0;
         scan_vld_ff  <= 1'b0;
         pivot_vld_ff <= 1'b0;
         asc_ff       <= 1'b1;
      end else begin
         fill_ff      <= fill_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         p_ff         <= p_in;
         rank_ff      <= rank_in;
         scan_vld_ff  <= scan_vld_in;
         pivot_vld_ff <= pivot_vld_in;
         asc_ff       <= asc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      pivot_ff     <= pivot_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // status
   always_comb begin
      sts.close_hit = req_last_in || ((fill_ff + CW'(1)) == CW'(MAX_ITEMS));
      sts.scan_end  = (j_ff == n_last);
      sts.pivot_end = (i_ff == n_last);
      sts.emit_end  = (p_ff == n_last);
   end

   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;

endmodule

[rtl/core/comparison_rank_sort.sv]
// comparison_rank_sort: top level of the comparison counting sorter
// depends on crs_pkg, crs_req_if, crs_rsp_if, crs_ctrl, crs_dp and crs_ram
// wires the channels and configuration port to controller and datapath
//
// Values are loaded one item per cycle into a value store until an item
// marked last, or the item that fills the store to MAX_ITEMS, closes the set.
// The block then ranks the n stored values: for each value it scans the whole
// value store through its single read port, and no input item is accepted
// while ranking runs. Each value is written to a sorted store at its rank, and
// results are read, loaded and offered one by one, each held until the sink
// takes it, smallest first when csr_wr_data last written was 1 (reset value)
// and largest first when 0. The last result carries last_out.
// Write the configuration bit only while no set is in progress.
module comparison_rank_sort
   import crs_pkg::*;
#(
   parameter int unsigned MAX_ITEMS = 64
) (
   input  logic      clock,
   input  logic      reset,
   crs_req_if.sink   req_chan,
   crs_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   crs_cmd_type cmd;
   crs_sts_type sts;

   // sequencer
   crs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   // stores and rank logic
   crs_dp #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_item_value  (req_chan.item_value),
      .req_last_in     (req_chan.last_in),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_sorted_value(rsp_chan.sorted_value),
      .rsp_last_out    (rsp_chan.last_out)
   );

endmodule

[verif/testbench.sv]
// testbench: self-checking bench for the comparison rank sorter
// depends on crs_req_if, crs_rsp_if and comparison_rank_sort
// predicts each sorted set at input time and checks every result item in order
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned MAX_ITEMS     = 64;
   localparam int          IDLE_LIMIT    = 20000;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          TAIL_CYCLES   = 40;
   localparam int          RANDOM_ITEMS  = 50;

   // value styles for generated items
   typedef enum int {
      VAL_ANY,
      VAL_NARROW,
      VAL_EXTREME
   } value_style_type;

   // receiver stall patterns
   typedef enum int {
      RX_STEADY,
      RX_CHOPPY,
      RX_LONG_STALL
   } rx_mode_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               last_out;
   } sorted_item_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   crs_req_if req_chan ();
   crs_rsp_if rsp_chan ();

   comparison_rank_sort #(
      .MAX_ITEMS(MAX_ITEMS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // sorter model state
   logic signed [31:0] set_values [MAX_ITEMS];
   logic [5:0]         set_ranks [MAX_ITEMS];
   logic [6:0]         set_fill;
   logic               order_ascending;
   sorted_item_type    sorted_expect_q [$];

   // run bookkeeping
   int fail_count;
   int items_sent;
   int sets_closed;
   int results_checked;
   int order_writes;
   int burst_left;
   int idle_cycles;
   int rx_cycle;
   int rx_stall_left;
   rx_mode_type rx_mode;
   sorted_item_type seen_item;
   sorted_item_type want_item;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // rank a new value against the stored set and queue the sorted set on close
   task automatic store_and_rank(input logic signed [31:0] value, input logic last_mark);
      int k;
      int n;
      int r;
      int pos;
      logic signed [31:0] ordered [MAX_ITEMS];
      sorted_item_type res;
      k = int'(set_fill);
      if (k >= MAX_ITEMS) k = 0;
      set_ranks[k] = '0;
      for (int i = 0; i < k; i++) begin
         if (set_values[i] < value) set_ranks[k] = set_ranks[k] + 6'd1;
         else set_ranks[i] = set_ranks[i] + 6'd1;
      end
      set_values[k] = value;
      n = k + 1;
      set_fill = 7'(n);
      if (!last_mark && n < MAX_ITEMS) return;
      for (int i = 0; i < n; i++) begin
         r = int'(set_ranks[i]);
         if (r >= n) r = n - 1;
         pos = order_ascending ? r : (n - 1 - r);
         ordered[pos] = set_values[i];
      end
      for (int i = 0; i < n; i++) begin
         res.sorted_value = ordered[i];
         res.last_out     = (i == n - 1);
         sorted_expect_q.push_back(res);
      end
      set_fill = '0;
      sets_closed++;
   endtask

   // send one item, entered and left at a falling edge
   task automatic send_item(input logic signed [31:0] value, input logic last_mark);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.item_value <= value;
      req_chan.last_in    <= last_mark;
      do @(posedge clock); while (!req_chan.ready);
      store_and_rank(value, last_mark);
      items_sent++;
      @(negedge clock);
   endtask

   // send a whole set, last mark on the final value
   task automatic send_set(input logic signed [31:0] values [$]);
      foreach (values[i]) send_item(values[i], i == values.size() - 1);
   endtask

   // hold the sender until every queued result item has come back
   task automatic wait_results_drained();
      req_chan.valid <= 1'b0;
      while (sorted_expect_q.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // change the sort direction between sets
   task automatic set_order(input logic ascending);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ascending;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      order_ascending = ascending;
      order_writes++;
   endtask

   function automatic logic signed [31:0] pick_value(input value_style_type style);
      logic signed [31:0] v;
      case (style)
         VAL_NARROW: v = $signed(32'($urandom_range(0, 7))) - 32'sd4;
         VAL_EXTREME: begin
            case ($urandom_range(0, 4))
               0: v = 32'sh7fffffff;
               1: v = 32'sh80000000;
               2: v = 32'sd0;
               3: v = -32'sd1;
               default: v = 32'sd1;
            endcase
         end
         default: v = $signed($urandom());
      endcase
      return v;
   endfunction

   function automatic value_style_type pick_style();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return VAL_ANY;
      if (sel < 9) return VAL_NARROW;
      return VAL_EXTREME;
   endfunction

   // extremes and bit patterns, in the reset order and then descending
   task automatic test_extremes();
      logic signed [31:0] vals [$];
      vals = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, 32'sd1,
               32'sh55555555, 32'shaaaaaaaa};
      send_set(vals);
      set_order(1'b0);
      send_set(vals);
   endtask

   // one-value set, repeated values and an all-equal set
   task automatic test_small_and_equal();
      logic signed [31:0] vals [$];
      vals = '{32'sd42};
      send_set(vals);
      set_order(1'b1);
      vals = '{32'sd5, 32'sd5, -32'sd3, 32'sd5, -32'sd3, 32'sd5};
      send_set(vals);
      vals = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
      send_set(vals);
   endtask

   // a full store closes the set with or without the last mark
   task automatic test_store_full();
      value_style_type style;
      set_order(1'b0);
      style = VAL_ANY;
      for (int i = 0; i < MAX_ITEMS; i++) send_item(pick_value(style), 1'b0);
      set_order(1'b1);
      style = VAL_NARROW;
      for (int i = 0; i < MAX_ITEMS; i++) send_item(pick_value(style), i == MAX_ITEMS - 1);
   endtask

   // random sets, mostly small, with direction changes between them
   task automatic test_random_sets();
      int target;
      int size;
      value_style_type style;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if ($urandom_range(0, 3) == 0) set_order(1'($urandom_range(0, 1)));
         size  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(11, 40);
         style = pick_style();
         for (int i = 0; i < size; i++) begin
            // mix styles inside a set now and then
            if ($urandom_range(0, 7) == 0) style = pick_style();
            send_item(pick_value(style), i == size - 1);
         end
      end
   endtask

   // receiver ready pattern
   initial begin
      rsp_chan.ready = 1'b0;
      rx_cycle       = 0;
      rx_stall_left  = 0;
      rx_mode        = RX_STEADY;
   end

   always @(negedge clock) begin
      logic next_ready;
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = rx_mode_type'($urandom_range(0, 2));
      next_ready = 1'b1;
      if (rx_stall_left > 0) begin
         rx_stall_left--;
         next_ready = 1'b0;
      end else begin
         case (rx_mode)
            RX_CHOPPY: next_ready = ($urandom_range(0, 3) != 0);
            RX_LONG_STALL: begin
               if ($urandom_range(0, 7) == 0) begin
                  rx_stall_left = $urandom_range(3, 12);
                  next_ready    = 1'b0;
               end
            end
            default: next_ready = 1'b1;
         endcase
      end
      rsp_chan.ready <= next_ready;
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen_item.sorted_value = rsp_chan.sorted_value;
         seen_item.last_out     = rsp_chan.last_out;
         if (sorted_expect_q.size() == 0) begin
            $error("unexpected result item: sorted_value %0d last_out %0b",
                   seen_item.sorted_value, seen_item.last_out);
            fail_count++;
         end else begin
            want_item = sorted_expect_q.pop_front();
            results_checked++;
            if (seen_item.sorted_value !== want_item.sorted_value) begin
               $error("sorted_value: expected %0d, actual %0d",
                      want_item.sorted_value, seen_item.sorted_value);
               fail_count++;
            end
            if (seen_item.last_out !== want_item.last_out) begin
               $error("last_out: expected %0b, actual %0b",
                      want_item.last_out, seen_item.last_out);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d result items pending",
                     IDLE_LIMIT, sorted_expect_q.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.item_value = '0;
      req_chan.last_in    = 1'b0;
      set_fill            = '0;
      order_ascending     = 1'b1;
      fail_count          = 0;
      items_sent          = 0;
      sets_closed         = 0;
      results_checked     = 0;
      order_writes        = 0;
      burst_left          = 0;
      idle_cycles         = 0;
      foreach (set_ranks[i]) set_ranks[i] = '0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_extremes();
      test_small_and_equal();
      test_store_full();
      test_random_sets();

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d input items in %0d sets, %0d result items checked",
               items_sent, sets_closed, results_checked);
      $display("sort direction written %0d times, full-store sets and equal values included",
               order_writes);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
